// ===== hdl/dgf_pkg.sv =====
// Shared constants and types of the disk graph flood simulator.
// No dependencies; every other file of the block but dgf_ram imports this package.
package dgf_pkg;

  localparam int MAX_NODES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TIME_WIDTH_DEF  = 16;

  localparam int NODE_W     = 3;
  localparam int SEED_TIME  = 100;   // 1.0 time unit in hundredths
  localparam int HOP_DELAY  = 10;    // 0.1 time unit in hundredths

  localparam int POS_W      = 32;
  localparam int RADIUS_W   = 36;
  localparam int NCOUNT_W   = 4;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_RADIUS     = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_POP   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    Q_NOP  = 2'd0,
    Q_PUSH = 2'd1,
    Q_POP  = 2'd2,
    Q_SEED = 2'd3
  } q_op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_BUILD = 2'd1,
    S_FWD   = 2'd2,
    S_RESP  = 2'd3
  } state_e;

endpackage

// ===== hdl/disk_graph_flood_event_sim.sv =====
// Packet flood over a unit-disk graph. A build item runs the single squared-distance pipeline,
// which visits one node pair per cycle. A pop that forwards steps through the neighbors from the
// highest index down, one neighbor per cycle into the queue; the queue is a row of QUEUE_DEPTH
// cells that takes one sorted insert or one removal per cycle. Input is accepted while a result waits.
module disk_graph_flood_event_sim #(
  parameter int MAX_NODES   = dgf_pkg::MAX_NODES_DEF,
  parameter int QUEUE_DEPTH = dgf_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = dgf_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // node_index[2:0], pos_x[18:3], pos_y[34:19], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // receiver[2:0], receive_time[18:3], forwarded[19], pad
  output logic [0:0]  m_axis_tuser,   // queue_empty[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import dgf_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TIME_WIDTH;

  // configuration
  logic [NCOUNT_W-1:0] ncount_q;
  logic [RADIUS_W-1:0] radius_q;
  logic                cfg_we;
  logic [NCOUNT_W-1:0] n_eff;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= NCOUNT_W'(8);
      radius_q <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == REG_NODE_COUNT) begin
        ncount_q <= pwdata[NCOUNT_W-1:0];
      end else begin
        radius_q <= pwdata[RADIUS_W-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_NODE_COUNT) ? {{(64-NCOUNT_W){1'b0}}, ncount_q}
                                               : {{(64-RADIUS_W){1'b0}}, radius_q};

  assign n_eff = (ncount_q == '0) ? NCOUNT_W'(1) :
                 (ncount_q > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES) : ncount_q;

  // input item fields
  func_e             func;
  logic [NODE_W-1:0] in_idx;
  logic              in_acc;
  assign func   = func_e'(s_axis_tuser);
  assign in_idx = s_axis_tdata[2:0];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d;

  // position store
  logic             pos_we;
  logic [AW-1:0]    rd_a, rd_b;
  logic [POS_W-1:0] pos_a, pos_b;
  assign pos_we = in_acc && (func == FUNC_LOAD) && (4'(in_idx) < 4'(MAX_NODES));

  dgf_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_pos_ram (
    .clk_i,
    .we_i(pos_we),
    .waddr_i(in_idx[AW-1:0]),
    .wdata_i({s_axis_tdata[18:3], s_axis_tdata[34:19]}),
    .raddr_a_i(rd_a),
    .raddr_b_i(rd_b),
    .rdata_a_o(pos_a),
    .rdata_b_o(pos_b)
  );

  // build pipeline: read, difference, square, sum and compare
  logic [2*AW:0]          pc_q;
  logic                   issue;
  logic                   v1_q, v2_q, v3_q;
  logic [AW-1:0]          i1_q, j1_q, i2_q, j2_q, i3_q, j3_q;
  logic signed [16:0]     dx_q, dy_q;
  logic signed [33:0]     px, py;
  logic [33:0]            sqx_q, sqy_q;
  logic [34:0]            d2;
  logic                   link;
  logic                   build_done;

  assign issue = (state_q == S_BUILD) && !pc_q[2*AW];
  assign rd_a  = pc_q[2*AW-1:AW];
  assign rd_b  = pc_q[AW-1:0];
  assign px    = dx_q * dx_q;
  assign py    = dy_q * dy_q;
  assign d2    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign link  = v3_q && (i3_q != j3_q) && (4'(i3_q) < n_eff) && (4'(j3_q) < n_eff)
                 && ({1'b0, d2} <= radius_q);
  assign build_done = pc_q[2*AW] && !v1_q && !v2_q && !v3_q;

  always_ff @(posedge clk_i) begin
    i1_q  <= rd_a;
    j1_q  <= rd_b;
    i2_q  <= i1_q;
    j2_q  <= j1_q;
    i3_q  <= i2_q;
    j3_q  <= j2_q;
    dx_q  <= $signed({pos_a[31], pos_a[31:16]}) - $signed({pos_b[31], pos_b[31:16]});
    dy_q  <= $signed({pos_a[15], pos_a[15:0]}) - $signed({pos_b[15], pos_b[15:0]});
    sqx_q <= $unsigned(px);
    sqy_q <= $unsigned(py);
  end

  // graph, marks and pop bookkeeping
  logic [MAX_NODES-1:0] adj_q [MAX_NODES];
  logic [MAX_NODES-1:0] sent_q;
  logic [AW-1:0]        k_q;
  logic [TW-1:0]        ev_time_q;
  logic [NODE_W-1:0]    ev_node_q;
  logic                 ev_fwd_q, ev_empty_q;

  q_op_e             q_op;
  logic [TW-1:0]     q_time;
  logic [NODE_W-1:0] q_node;
  logic [TW-1:0]     head_time;
  logic [NODE_W-1:0] head_node;
  logic [CW-1:0]     q_count;
  logic [TW:0]       hop_sum;
  logic              head_new;
  logic              slot_free;

  dgf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_WIDTH(TW)) u_queue (
    .clk_i, .rst_ni,
    .op_i(q_op),
    .new_time_i(q_time),
    .new_node_i(q_node),
    .head_time_o(head_time),
    .head_node_o(head_node),
    .count_o(q_count)
  );

  assign hop_sum   = {1'b0, ev_time_q} + (TW+1)'(HOP_DELAY) + (TW+1)'(k_q);
  assign head_new  = !sent_q[head_node[AW-1:0]];
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    q_op    = Q_NOP;
    q_time  = TW'(SEED_TIME);
    q_node  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func)
            FUNC_LOAD:  ;
            FUNC_BUILD: begin
              q_op    = Q_SEED;
              state_d = S_BUILD;
            end
            FUNC_POP: begin
              if (q_count != '0) begin
                q_op    = Q_POP;
                state_d = head_new ? S_FWD : S_RESP;
              end else begin
                state_d = S_RESP;
              end
            end
            FUNC_NONE:  ;
          endcase
        end
      end
      S_BUILD: begin
        if (build_done) state_d = S_IDLE;
      end
      S_FWD: begin
        q_node = NODE_W'(k_q);
        q_time = hop_sum[TW] ? {TW{1'b1}} : hop_sum[TW-1:0];
        if (adj_q[ev_node_q[AW-1:0]][k_q]) q_op = Q_PUSH;
        if (k_q == '0) state_d = S_RESP;
      end
      S_RESP: begin
        if (slot_free) state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      sent_q  <= '0;
      for (int r = 0; r < MAX_NODES; r++) adj_q[r] <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (issue) pc_q <= pc_q + 1'b1;
      if (link) adj_q[i3_q][j3_q] <= 1'b1;
      if (state_q == S_IDLE && in_acc && func == FUNC_BUILD) begin
        pc_q   <= '0;
        sent_q <= '0;
        for (int r = 0; r < MAX_NODES; r++) adj_q[r] <= '0;
      end
      if (state_q == S_IDLE && in_acc && func == FUNC_POP && q_count != '0 && head_new) begin
        sent_q[head_node[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && func == FUNC_POP) begin
      k_q <= AW'(MAX_NODES - 1);
      if (q_count != '0) begin
        ev_time_q  <= head_time;
        ev_node_q  <= head_node;
        ev_fwd_q   <= head_new;
        ev_empty_q <= 1'b0;
      end else begin
        ev_time_q  <= '0;
        ev_node_q  <= '0;
        ev_fwd_q   <= 1'b0;
        ev_empty_q <= 1'b1;
      end
    end else if (state_q == S_FWD) begin
      k_q <= k_q - 1'b1;
    end
  end

  // output register
  logic [TW+15:0] time_ext;
  logic [15:0]    out_time_q;
  logic [2:0]     out_recv_q;
  logic           out_fwd_q, out_empty_q, out_valid_q;
  logic           out_load;

  assign time_ext = {16'b0, ev_time_q};
  assign out_load = (state_q == S_RESP) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_recv_q  <= ev_node_q;
      out_time_q  <= time_ext[15:0];
      out_fwd_q   <= ev_fwd_q;
      out_empty_q <= ev_empty_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_fwd_q, out_time_q, out_recv_q};
  assign m_axis_tuser  = out_empty_q;

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty result carries nonzero fields");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("event count above queue depth");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_build_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && in_acc && func == FUNC_BUILD |=> q_count == CW'(1))
    else $error("build did not leave a single seed event");

endmodule

// ===== hdl/dgf_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module dgf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/dgf_cell.sv =====
// One slot of the sorted event queue: holds {time, node}, hands it to a neighbor.
// Depends on dgf_pkg.
module dgf_cell #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                      clk_i,
  input  dgf_pkg::q_op_e            op_i,
  input  logic                      valid_i,
  input  logic                      left_valid_i,
  input  logic                      left_gt_i,
  input  logic [TIME_WIDTH-1:0]     left_time_i,
  input  logic [dgf_pkg::NODE_W-1:0] left_node_i,
  input  logic [TIME_WIDTH-1:0]     right_time_i,
  input  logic [dgf_pkg::NODE_W-1:0] right_node_i,
  input  logic [TIME_WIDTH-1:0]     new_time_i,
  input  logic [dgf_pkg::NODE_W-1:0] new_node_i,
  output logic [TIME_WIDTH-1:0]     time_o,
  output logic [dgf_pkg::NODE_W-1:0] node_o,
  output logic                      gt_o
);
  import dgf_pkg::*;

  logic [TIME_WIDTH-1:0] time_q;
  logic [NODE_W-1:0]     node_q;

  // strictly later entries move right, so equal times keep insertion order
  assign gt_o   = valid_i && (time_q > new_time_i);
  assign time_o = time_q;
  assign node_o = node_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      Q_PUSH: begin
        if (left_gt_i) begin
          time_q <= left_time_i;
          node_q <= left_node_i;
        end else if ((gt_o || !valid_i) && left_valid_i) begin
          time_q <= new_time_i;
          node_q <= new_node_i;
        end
      end
      Q_POP: begin
        time_q <= right_time_i;
        node_q <= right_node_i;
      end
      Q_SEED: begin
        time_q <= new_time_i;
        node_q <= new_node_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/dgf_queue.sv =====
// Sorted event queue built as a row of dgf_cell slots plus an occupancy count.
// Depends on dgf_pkg and dgf_cell.
module dgf_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dgf_pkg::q_op_e                    op_i,
  input  logic [TIME_WIDTH-1:0]             new_time_i,
  input  logic [dgf_pkg::NODE_W-1:0]        new_node_i,
  output logic [TIME_WIDTH-1:0]             head_time_o,
  output logic [dgf_pkg::NODE_W-1:0]        head_node_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  count_o
);
  import dgf_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]         count_q, count_d;
  logic                  full;
  q_op_e                 cell_op;
  logic [TIME_WIDTH-1:0] time_w [QUEUE_DEPTH];
  logic [NODE_W-1:0]     node_w [QUEUE_DEPTH];
  logic                  gt_w   [QUEUE_DEPTH];
  logic                  valid_w[QUEUE_DEPTH];

  assign full    = (count_q >= CW'(QUEUE_DEPTH));
  // drop a push into a full queue
  assign cell_op = (op_i == Q_PUSH && full) ? Q_NOP : op_i;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign valid_w[g] = (CW'(g) < count_q);
    if (g == 0) begin : g_first
      dgf_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk_i, .op_i(cell_op), .valid_i(valid_w[g]),
        .left_valid_i(1'b1), .left_gt_i(1'b0),
        .left_time_i(new_time_i), .left_node_i(new_node_i),
        .right_time_i(time_w[g+1]), .right_node_i(node_w[g+1]),
        .new_time_i, .new_node_i,
        .time_o(time_w[g]), .node_o(node_w[g]), .gt_o(gt_w[g])
      );
    end else if (g == QUEUE_DEPTH - 1) begin : g_last
      dgf_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk_i, .op_i(cell_op), .valid_i(valid_w[g]),
        .left_valid_i(valid_w[g-1]), .left_gt_i(gt_w[g-1]),
        .left_time_i(time_w[g-1]), .left_node_i(node_w[g-1]),
        .right_time_i(time_w[g]), .right_node_i(node_w[g]),
        .new_time_i, .new_node_i,
        .time_o(time_w[g]), .node_o(node_w[g]), .gt_o(gt_w[g])
      );
    end else begin : g_mid
      dgf_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk_i, .op_i(cell_op), .valid_i(valid_w[g]),
        .left_valid_i(valid_w[g-1]), .left_gt_i(gt_w[g-1]),
        .left_time_i(time_w[g-1]), .left_node_i(node_w[g-1]),
        .right_time_i(time_w[g+1]), .right_node_i(node_w[g+1]),
        .new_time_i, .new_node_i,
        .time_o(time_w[g]), .node_o(node_w[g]), .gt_o(gt_w[g])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    case (cell_op)
      Q_PUSH:  count_d = count_q + CW'(1);
      Q_POP:   count_d = count_q - CW'(1);
      Q_SEED:  count_d = CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_time_o = time_w[0];
  assign head_node_o = node_w[0];
  assign count_o     = count_q;

endmodule

// ===== test/dgf_checker.sv =====
// Checker for the disk graph flood simulator: watches the config port and both streams,
// predicts every pop result and compares it field by field. Depends on dgf_pkg.
`timescale 1ns / 100ps
module dgf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending_events
);
  import dgf_pkg::*;

  typedef struct packed {
    logic [2:0]  receiver;
    logic [15:0] rx_time;
    logic        forwarded;
    logic        empty;
  } pop_result_t;

  pop_result_t   pop_results[$];
  logic [31:0]   positions[MAX_NODES_DEF];
  logic [7:0]    links[MAX_NODES_DEF];
  logic [7:0]    sent;
  int            ev_time[QUEUE_DEPTH_DEF];
  int            ev_node[QUEUE_DEPTH_DEF];
  int            ev_cnt;
  logic [3:0]    node_cnt;
  logic [35:0]   radius_sq;

  assign pending_events = pop_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void queue_event(input int t, input int node);
    int pos;
    pos = 0;
    if (ev_cnt >= QUEUE_DEPTH_DEF) return;
    while (pos < ev_cnt && ev_time[pos] <= t) pos++;
    for (int k = ev_cnt; k > pos; k--) begin
      ev_time[k] = ev_time[k-1];
      ev_node[k] = ev_node[k-1];
    end
    ev_time[pos] = t;
    ev_node[pos] = node;
    ev_cnt++;
  endfunction

  function automatic void build_links();
    int     n;
    longint dx, dy, d2;
    n = (node_cnt == 0) ? 1 : (node_cnt > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_cnt);
    for (int i = 0; i < MAX_NODES_DEF; i++) links[i] = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i == j) continue;
        dx = longint'($signed(positions[i][31:16])) - longint'($signed(positions[j][31:16]));
        dy = longint'($signed(positions[i][15:0])) - longint'($signed(positions[j][15:0]));
        d2 = dx * dx + dy * dy;
        if (d2 <= longint'(radius_sq)) links[i][j] = 1'b1;
      end
    end
    sent = '0;
    ev_cnt = 0;
    queue_event(SEED_TIME, 0);
  endfunction

  function automatic pop_result_t pop_flood_event();
    pop_result_t r;
    int t, node, nt;
    r = '0;
    if (ev_cnt == 0) begin
      r.empty = 1'b1;
      return r;
    end
    t = ev_time[0];
    node = ev_node[0];
    for (int k = 0; k < ev_cnt - 1; k++) begin
      ev_time[k] = ev_time[k+1];
      ev_node[k] = ev_node[k+1];
    end
    ev_cnt--;
    if (!sent[node]) begin
      sent[node] = 1'b1;
      r.forwarded = 1'b1;
      // neighbors go in from the highest index down
      for (int k = MAX_NODES_DEF - 1; k >= 0; k--) begin
        if (links[node][k]) begin
          nt = t + HOP_DELAY + k;
          if (nt > (1 << TIME_WIDTH_DEF) - 1) nt = (1 << TIME_WIDTH_DEF) - 1;
          queue_event(nt, k);
        end
      end
    end
    r.receiver = node[2:0];
    r.rx_time = t[15:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    ev_cnt = 0;
    sent = '0;
    node_cnt = 4'd8;
    radius_sq = '0;
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      positions[i] = '0;
      links[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    pop_result_t want;
    func_e       fn;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == REG_NODE_COUNT) node_cnt = pwdata[3:0];
        else radius_sq = pwdata[35:0];
      end
      // compare first: a result never comes from the item taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (pop_results.size() == 0) begin
          report("unexpected result", m_axis_tdata[2:0], -1);
        end else begin
          want = pop_results.pop_front();
          if (m_axis_tdata[2:0] !== want.receiver)
            report("receiver", m_axis_tdata[2:0], want.receiver);
          if (m_axis_tdata[18:3] !== want.rx_time)
            report("receive_time", m_axis_tdata[18:3], want.rx_time);
          if (m_axis_tdata[19] !== want.forwarded)
            report("forwarded", m_axis_tdata[19], want.forwarded);
          if (m_axis_tuser[0] !== want.empty)
            report("queue_empty", m_axis_tuser[0], want.empty);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fn = func_e'(s_axis_tuser);
        case (fn)
          FUNC_LOAD:  positions[s_axis_tdata[2:0]] = {s_axis_tdata[18:3], s_axis_tdata[34:19]};
          FUNC_BUILD: build_links();
          FUNC_POP:   pop_results.push_back(pop_flood_event());
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the disk graph flood testbench: clock, reset, stimulus, config writes and verdict.
// Depends on dgf_pkg, the block and dgf_checker.
`timescale 1ns / 100ps
module tb;
  import dgf_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1850;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count, pending_events;
  int burst_left = 0;
  int sent_items = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  always #1 clk_i = ~clk_i;

  disk_graph_flood_event_sim dut (.*);

  dgf_checker u_checker (.*);

  task automatic send_item(input func_e fn, input logic [2:0] idx,
                           input logic [15:0] x, input logic [15:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {5'b0, y, x, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  // wait out the last result plus a full build and a forwarding pop
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_events != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] coord(input int span);
    if (span >= 32768) return 16'($urandom());
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic flood_phase(input logic [3:0] nodes, input logic [35:0] rad, input int span);
    int pops;
    settle();
    write_reg(REG_NODE_COUNT, {60'b0, nodes});
    write_reg(REG_RADIUS, {28'b0, rad});
    for (int i = 0; i < MAX_NODES_DEF; i++) send_item(FUNC_LOAD, 3'(i), coord(span), coord(span));
    send_item(FUNC_BUILD, '0, '0, '0);
    pops = $urandom_range(4, 30);
    for (int p = 0; p < pops; p++) begin
      case ($urandom_range(0, 19))
        0: send_item(FUNC_NONE, 3'($urandom()), 16'($urandom()), 16'($urandom()));
        1: send_item(FUNC_LOAD, 3'($urandom()), coord(span), coord(span));
        2: send_item(FUNC_BUILD, 3'($urandom()), 16'($urandom()), 16'($urandom()));
        default: send_item(FUNC_POP, 3'($urandom()), 16'($urandom()), 16'($urandom()));
      endcase
    end
  endtask

  // receiver: random stall pattern, plain stretches, and long hold-offs on request
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 400;
        while (hold > 0) begin
          m_axis_tready <= 1'b0;
          hold--;
          @(posedge clk_i);
        end
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (left % 4 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [3:0] nodes;
    logic [35:0] rad;
    int span;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pop before build, coordinate extremes, every func, full and empty graphs
    send_item(FUNC_POP, '0, '0, '0);
    send_item(FUNC_LOAD, 3'd0, 16'h8000, 16'h8000);
    send_item(FUNC_LOAD, 3'd1, 16'h7fff, 16'h7fff);
    send_item(FUNC_LOAD, 3'd2, 16'h8000, 16'h7fff);
    send_item(FUNC_LOAD, 3'd3, 16'h7fff, 16'h8000);
    for (int i = 4; i < 8; i++) send_item(FUNC_LOAD, 3'(i), 16'(i), 16'(-i));
    send_item(FUNC_NONE, 3'd7, 16'hffff, 16'hffff);
    send_item(FUNC_BUILD, '0, '0, '0);
    repeat (3) send_item(FUNC_POP, '0, '0, '0);
    flood_phase(4'd8, 36'hf_ffff_ffff, 32768);
    repeat (40) send_item(FUNC_POP, '0, '0, '0);
    flood_phase(4'd0, 36'd0, 100);
    flood_phase(4'd15, 36'd0, 0);
    repeat (10) send_item(FUNC_POP, '0, '0, '0);

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items > 600 && sent_items < 700) hold_request = 1'b1;
      case ($urandom_range(0, 9))
        0: nodes = 4'($urandom_range(9, 15));
        1: nodes = 4'($urandom_range(0, 1));
        default: nodes = 4'($urandom_range(2, 8));
      endcase
      span = ($urandom_range(0, 5) == 0) ? 32768 : $urandom_range(16, 1000);
      case ($urandom_range(0, 9))
        0: rad = 36'hf_ffff_ffff;
        1: rad = '0;
        default: rad = 36'($urandom_range(0, 3) * span * span / 2 + $urandom_range(0, 255));
      endcase
      flood_phase(nodes, rad, span);
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
